FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int Capacity = 16;
  localparam int CntW = $clog2(Capacity + 1);
  localparam int EntryTotalW = 5;
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  typedef enum logic {
    ModeInsert = 1'b0,
    ModeRemove = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic        [15:0] item_id;
    logic signed [15:0] item_priority;
  } in_t;

  typedef struct packed {
    logic                   success;
    logic            [15:0] removed_id;
    logic signed     [15:0] removed_priority;
    logic            [15:0] head_id;
    logic signed     [15:0] head_priority;
    logic [EntryTotalW-1:0] entry_total;
    logic                   is_empty;
    logic                   is_full;
  } out_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic        [15:0] id;
  } entry_t;

  typedef struct packed {
    logic   en;
    logic   remove;
    entry_t fresh;
  } cell_cmd_t;

endpackage

FILE: sv/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_cmd_t cmd_i,
  input  logic               live_i,
  input  logic               prev_take_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  output logic               take_o,
  output spq_pkg::entry_t    entry_o
);
  import spq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // A cell takes part in an insert when it is empty or the new entry outranks it.
  assign take_o = !live_i || ($signed(cmd_i.fresh.prio) > $signed(entry_q.prio));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.remove) begin
      entry_d = right_i;
    end else if (take_o && !prev_take_i) begin
      entry_d = cmd_i.fresh;
    end else if (take_o) begin
      entry_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: sv/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// A result appears in the output register in the cycle after its request is accepted.
// One request per cycle unless in_stall_o is high; all cells shift or insert together.
// Input stall is raised only while a held result is itself stalled at the output.
// Reset clears the entry count and the output valid; cell contents are not reset.

module sorted_priority_queue_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  spq_pkg::in_t in_req_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output spq_pkg::out_t out_rsp_o
);
  import spq_pkg::*;

  logic            accept;
  logic            is_insert;
  logic            ok;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            out_valid_q;
  out_t            out_q;
  out_t            out_d;
  cell_cmd_t       cmd;
  entry_t          head_sel;

  entry_t          entries [Capacity];
  entry_t          lefts   [Capacity];
  entry_t          rights  [Capacity];
  logic            takes   [Capacity];
  logic            prevs   [Capacity];
  logic            lives   [Capacity];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_insert  = (in_req_i.mode == ModeInsert);
  assign ok         = is_insert ? (count_q < CapCnt) : (count_q != '0);

  assign cmd.en         = accept && ok;
  assign cmd.remove     = !is_insert;
  assign cmd.fresh.prio = in_req_i.item_priority;
  assign cmd.fresh.id   = in_req_i.item_id;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign lives[i]  = CntW'(i) < count_q;
    assign prevs[i]  = (i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i - 1];
    assign lefts[i]  = (i == 0) ? entry_t'('0) : entries[(i == 0) ? 0 : i - 1];
    assign rights[i] = (i + 1 < Capacity) ? entries[(i + 1 < Capacity) ? i + 1 : i]
                                          : entry_t'('0);

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .live_i      (lives[i]),
      .prev_take_i (prevs[i]),
      .left_i      (lefts[i]),
      .right_i     (rights[i]),
      .take_o      (takes[i]),
      .entry_o     (entries[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    head_sel = entries[0];
    if (ok) begin
      if (is_insert) begin
        count_d  = count_q + CntW'(1);
        head_sel = takes[0] ? cmd.fresh : entries[0];
      end else begin
        count_d  = count_q - CntW'(1);
        head_sel = rights[0];
      end
    end
  end

  always_comb begin
    out_d                  = '0;
    out_d.success          = ok;
    if (ok && !is_insert) begin
      out_d.removed_id       = entries[0].id;
      out_d.removed_priority = entries[0].prio;
    end
    if (count_d != '0) begin
      out_d.head_id       = head_sel.id;
      out_d.head_priority = head_sel.prio;
    end
    out_d.entry_total = EntryTotalW'(count_d);
    out_d.is_empty    = (count_d == '0);
    out_d.is_full     = (count_d >= CapCnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.en) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("Entry count exceeds capacity.");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_insert && (count_q == CapCnt) |=> out_valid_o && !out_rsp_o.success)
    else $error("Insert into a full queue was not rejected.");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_insert && (count_q != '0) |=> count_q == $past(count_q) - CntW'(1))
    else $error("Remove did not decrement the entry count.");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (count_d == '0) |=> (out_rsp_o.head_id == '0) && out_rsp_o.is_empty)
    else $error("Empty queue reported a head entry.");
`endif

endmodule

FILE: tb/sv/priority_queue_checker.sv
`timescale 1ns / 1ps

module priority_queue_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  spq_pkg::in_t  in_req_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  spq_pkg::out_t out_rsp_i,
  output int            fail_count_o,
  output int            pending_o
);
  import spq_pkg::*;

  entry_t shadow_entries [Capacity];
  int     shadow_count;
  out_t   predicted_results [$];
  out_t   oldest_rsp;

  function automatic out_t predict_queue_op(in_t req);
    out_t rsp;
    int   pos;
    rsp = '0;
    if (req.mode == ModeInsert) begin
      if (shadow_count < Capacity) begin
        pos = shadow_count;
        while (pos > 0 &&
               $signed(req.item_priority) > $signed(shadow_entries[pos-1].prio)) begin
          shadow_entries[pos] = shadow_entries[pos-1];
          pos--;
        end
        shadow_entries[pos].prio = req.item_priority;
        shadow_entries[pos].id = req.item_id;
        shadow_count++;
        rsp.success = 1'b1;
      end
    end else if (shadow_count > 0) begin
      rsp.success = 1'b1;
      rsp.removed_id = shadow_entries[0].id;
      rsp.removed_priority = shadow_entries[0].prio;
      for (int i = 0; i + 1 < shadow_count; i++) begin
        shadow_entries[i] = shadow_entries[i+1];
      end
      shadow_count--;
    end
    if (shadow_count > 0) begin
      rsp.head_id = shadow_entries[0].id;
      rsp.head_priority = shadow_entries[0].prio;
    end
    rsp.entry_total = EntryTotalW'(shadow_count);
    rsp.is_empty = (shadow_count == 0);
    rsp.is_full = (shadow_count >= Capacity);
    return rsp;
  endfunction

  task automatic compare_field(string name, logic signed [31:0] exp_v,
                               logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      predicted_results.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count_o++;
        end else begin
          oldest_rsp = predicted_results.pop_front();
          compare_field("success", oldest_rsp.success, out_rsp_i.success);
          compare_field("removed_id", oldest_rsp.removed_id, out_rsp_i.removed_id);
          compare_field("removed_priority", $signed(oldest_rsp.removed_priority),
                        $signed(out_rsp_i.removed_priority));
          compare_field("head_id", oldest_rsp.head_id, out_rsp_i.head_id);
          compare_field("head_priority", $signed(oldest_rsp.head_priority),
                        $signed(out_rsp_i.head_priority));
          compare_field("entry_total", oldest_rsp.entry_total, out_rsp_i.entry_total);
          compare_field("is_empty", oldest_rsp.is_empty, out_rsp_i.is_empty);
          compare_field("is_full", oldest_rsp.is_full, out_rsp_i.is_full);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_results.push_back(predict_queue_op(in_req_i));
      end
    end
    pending_o = predicted_results.size();
  end

endmodule

FILE: tb/sv/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldOffCycles = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_rsp;

  int fail_count;
  int pending;
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_off_req = 1'b0;

  sorted_priority_queue_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  priority_queue_checker checker_u (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic send_request(in_t req);
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_insert(logic [15:0] id, logic signed [15:0] prio);
    in_t req;
    req.mode = ModeInsert;
    req.item_id = id;
    req.item_priority = prio;
    send_request(req);
  endtask

  function automatic in_t random_request(int insert_pct);
    in_t req;
    int  pick;
    req.mode = ($urandom_range(0, 99) < insert_pct) ? ModeInsert : ModeRemove;
    req.item_id = 16'($urandom());
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      req.item_priority = 16'($urandom());
    end else if (pick < 8) begin
      req.item_priority = 16'($urandom_range(0, 8)) - 16'sd4;
    end else begin
      req.item_priority = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    return req;
  endfunction

  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_t req;
    int  insert_pct;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A remove from the empty queue must be rejected whatever its item fields hold.
    req.mode = ModeRemove;
    req.item_id = 16'hffff;
    req.item_priority = 16'sh7fff;
    send_request(req);
    send_insert(16'hffff, 16'sh7fff);
    send_insert(16'h0000, 16'sh8000);
    send_insert(16'h1234, 16'sd0);
    send_insert(16'h0001, 16'sd5);
    send_insert(16'h0002, 16'sd5);
    send_insert(16'h0003, 16'sd5);
    send_insert(16'h0004, -16'sd1);
    send_insert(16'h0005, 16'sd1);
    send_insert(16'h0006, 16'sd5);
    send_insert(16'h0007, 16'sd100);
    send_insert(16'h0008, -16'sd100);
    send_insert(16'h0009, 16'sh7fff);
    send_insert(16'h000a, 16'sh8000);
    send_insert(16'h000b, 16'sd7);
    send_insert(16'h000c, 16'sd7);
    send_insert(16'h000d, 16'sd0);
    // The queue is full now, so this insert must be rejected.
    send_insert(16'haaaa, 16'sh5555);
    req.item_id = 16'h0000;
    req.item_priority = 16'sh8000;
    repeat (4) send_request(req);

    // The receiver holds off while requests keep coming, so the block backs up.
    hold_off_req = 1'b1;
    repeat (40) send_request(random_request(50));
    wait (!hold_off_req);

    for (int chunk = 0; chunk < 24; chunk++) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 25;
        1: insert_pct = 50;
        default: insert_pct = 80;
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 40;
      endcase
      repeat (60) send_request(random_request(insert_pct));
    end

    gap_pct = 0;
    stall_pct = 0;
    for (int chunk = 0; chunk < 5; chunk++) begin
      insert_pct = (chunk % 2 == 0) ? 75 : 30;
      repeat (60) send_request(random_request(insert_pct));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
